@@ rtl/core/ght_pkg.sv @@
// package for the generational handle table: codes, widths and controller states
`timescale 1ns / 1ps
package ght_pkg;
  localparam int SLOT_COUNT_DEF = 1024;
  localparam logic [6:0] REUSE_MASK = 7'h7F;

  typedef enum logic [2:0] {
    OP_ALLOC  = 3'd0,
    OP_FREE   = 3'd1,
    OP_TYPED  = 3'd2,
    OP_ANY    = 3'd3,
    OP_VALID  = 3'd4
  } op_t;

  typedef enum logic [2:0] {
    ST_OK     = 3'd0,
    ST_FULL   = 3'd1,
    ST_RANGE  = 3'd2,
    ST_UNUSED = 3'd3,
    ST_TYPE   = 3'd4,
    ST_STALE  = 3'd5,
    ST_STOCK  = 3'd6
  } status_t;

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_SCAN,
    S_READ,
    S_EXEC,
    S_DONE
  } state_t;

  typedef struct packed {
    logic clear_step;
    logic latch;
    logic scan_step;
    logic read_req;
    logic exec;
    logic done;
  } cmd_t;

  typedef struct packed {
    logic clear_last;
    logic scan_found;
    logic scan_end;
    logic need_scan;
    logic need_read;
  } stat_t;
endpackage

@@ rtl/core/generational_handle_table_top.sv @@
// top level of the generational handle table
// channel | ports                                             | handshake
// input   | opcode slot_index object_type reuse_tag ...       | start && !busy
// result  | status granted_index ... live_count               | done, one cycle
// allocate: latch, hint search past the used slots, memory read, execute, strobe
// a full table ends the hint search and answers without a memory read
// other operations: latch, slot read, execute, strobe; stock, range, unused skip the read
// after reset a clearing pass over every slot runs with busy high
// results cannot be stalled; the next item is taken once busy falls
`timescale 1ns / 1ps
module generational_handle_table_top #(
  parameter int SLOT_COUNT = ght_pkg::SLOT_COUNT_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  logic [2:0]  opcode,
  input  logic [15:0] slot_index,
  input  logic [7:0]  object_type,
  input  logic [6:0]  reuse_tag,
  input  logic        is_stock,
  input  logic [31:0] object_tag,
  output logic        done,
  output logic [2:0]  status,
  output logic [15:0] granted_index,
  output logic [6:0]  granted_reuse,
  output logic [31:0] found_object,
  output logic [7:0]  entry_type,
  output logic        is_valid,
  output logic [16:0] live_count
);
  ght_pkg::cmd_t cmd;
  ght_pkg::stat_t st;

  ght_ctrl u_ctrl (.clk(clk), .rst(rst), .start(start), .busy(busy), .st(st), .cmd(cmd));

  ght_dp #(.SLOT_COUNT(SLOT_COUNT)) u_dp (
    .clk(clk), .rst(rst), .cmd(cmd), .st(st),
    .opcode(opcode), .slot_index(slot_index), .object_type(object_type),
    .reuse_tag(reuse_tag), .is_stock(is_stock), .object_tag(object_tag),
    .done(done), .status(status), .granted_index(granted_index),
    .granted_reuse(granted_reuse), .found_object(found_object),
    .entry_type(entry_type), .is_valid(is_valid), .live_count(live_count)
  );

  a_done_busy: assert property (@(posedge clk) disable iff (rst) done |-> busy)
    else $error("result strobe while idle");
  a_done_pulse: assert property (@(posedge clk) disable iff (rst) done |=> !done)
    else $error("result strobe longer than one cycle");
  a_live_nz: assert property (@(posedge clk) disable iff (rst) live_count != 17'd0)
    else $error("live count lost the reserved slot");
endmodule

@@ rtl/core/ght_ram.sv @@
// generic single port ram with registered read
`timescale 1ns / 1ps
module ght_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];
  always_ff @(posedge clk) begin
    if (we) mem[addr] <= wdata;
    rdata <= mem[addr];
  end
endmodule

@@ rtl/core/ght_ctrl.sv @@
// controller state machine for the handle table
`timescale 1ns / 1ps
module ght_ctrl (
  input  logic           clk,
  input  logic           rst,
  input  logic           start,
  output logic           busy,
  input  ght_pkg::stat_t st,
  output ght_pkg::cmd_t  cmd
);
  ght_pkg::state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) state <= ght_pkg::S_CLEAR;
    else state <= state_next;
  end

  always_comb begin
    state_next = state;
    case (state)
      ght_pkg::S_CLEAR: if (st.clear_last) state_next = ght_pkg::S_IDLE;
      ght_pkg::S_IDLE: if (start) state_next = ght_pkg::S_SCAN;
      ght_pkg::S_SCAN: begin
        if (!st.need_scan) state_next = st.need_read ? ght_pkg::S_READ : ght_pkg::S_EXEC;
        else if (st.scan_found) state_next = ght_pkg::S_READ;
        else if (st.scan_end) state_next = ght_pkg::S_EXEC;
      end
      ght_pkg::S_READ: state_next = ght_pkg::S_EXEC;
      ght_pkg::S_EXEC: state_next = ght_pkg::S_DONE;
      ght_pkg::S_DONE: state_next = ght_pkg::S_IDLE;
      default: state_next = ght_pkg::S_IDLE;
    endcase
  end

  always_comb begin
    cmd = '0;
    busy = 1'b1;
    case (state)
      ght_pkg::S_CLEAR: cmd.clear_step = 1'b1;
      ght_pkg::S_IDLE: begin
        busy = 1'b0;
        cmd.latch = start;
      end
      ght_pkg::S_SCAN: cmd.scan_step = st.need_scan;
      ght_pkg::S_READ: cmd.read_req = 1'b1;
      ght_pkg::S_EXEC: cmd.exec = 1'b1;
      ght_pkg::S_DONE: cmd.done = 1'b1;
      default: busy = 1'b1;
    endcase
  end
endmodule

@@ rtl/core/ght_dp.sv @@
// datapath: used-bit vector, slot memory, search and checks
`timescale 1ns / 1ps
module ght_dp #(
  parameter int SLOT_COUNT = ght_pkg::SLOT_COUNT_DEF
) (
  input  logic           clk,
  input  logic           rst,
  input  ght_pkg::cmd_t  cmd,
  output ght_pkg::stat_t st,
  input  logic [2:0]     opcode,
  input  logic [15:0]    slot_index,
  input  logic [7:0]     object_type,
  input  logic [6:0]     reuse_tag,
  input  logic           is_stock,
  input  logic [31:0]    object_tag,
  output logic           done,
  output logic [2:0]     status,
  output logic [15:0]    granted_index,
  output logic [6:0]     granted_reuse,
  output logic [31:0]    found_object,
  output logic [7:0]     entry_type,
  output logic           is_valid,
  output logic [16:0]    live_count
);
  localparam int AW = $clog2(SLOT_COUNT);
  localparam int LW = $clog2(SLOT_COUNT + 1);
  localparam int MW = 8 + 7 + 32;
  localparam logic [AW-1:0] LAST = AW'(SLOT_COUNT - 1);

  logic [SLOT_COUNT-1:0] used;
  logic [AW-1:0] hint, ptr, clr, slot;
  logic [LW-1:0] live;
  logic wrapped;
  logic [2:0] op;
  logic [15:0] idx;
  logic [7:0] typ;
  logic [6:0] tag;
  logic stock;
  logic [31:0] obj;
  logic found;

  logic ram_we;
  logic [AW-1:0] ram_addr;
  logic [MW-1:0] ram_wdata, ram_rdata;
  logic [7:0] r_type;
  logic [6:0] r_reuse, new_reuse;
  logic [31:0] r_obj;
  logic bad, alloc;

  assign alloc = (op == 3'(ght_pkg::OP_ALLOC));
  assign bad = (idx == 16'd0) || ({16'd0, idx} >= 32'(SLOT_COUNT));
  assign {r_type, r_reuse, r_obj} = ram_rdata;
  assign new_reuse = (r_reuse + 7'd1) & ght_pkg::REUSE_MASK;

  assign st.clear_last = (clr == LAST);
  assign st.scan_found = !used[ptr];
  assign st.scan_end = wrapped && (ptr == hint - AW'(1) || hint == AW'(1)) || (wrapped && ptr == LAST);
  assign st.need_scan = alloc && !found;
  assign st.need_read = !alloc && op <= 3'(ght_pkg::OP_VALID) && !stock && !bad
                        && used[idx[AW-1:0]];

  always_comb begin
    ram_we = 1'b0;
    ram_addr = alloc ? slot : idx[AW-1:0];
    ram_wdata = '0;
    if (cmd.clear_step) begin
      ram_we = 1'b1;
      ram_addr = clr;
    end else if (cmd.exec && alloc && found) begin
      ram_we = 1'b1;
      ram_wdata = {typ, new_reuse, obj};
    end else if (cmd.exec && st.need_read && op == 3'(ght_pkg::OP_FREE)
                 && r_type == typ) begin
      ram_we = 1'b1;
      ram_wdata = {r_type, r_reuse, 32'd0};
    end
  end

  ght_ram #(.WIDTH(MW), .DEPTH(SLOT_COUNT)) u_ram (
    .clk(clk), .we(ram_we), .addr(ram_addr), .wdata(ram_wdata), .rdata(ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      used <= {{(SLOT_COUNT-1){1'b0}}, 1'b1};
      hint <= AW'(1);
      live <= LW'(1);
      clr <= '0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (cmd.clear_step) clr <= clr + AW'(1);
      if (cmd.latch) begin
        op <= opcode; idx <= slot_index; typ <= object_type;
        tag <= reuse_tag; stock <= is_stock; obj <= object_tag;
        ptr <= hint; wrapped <= 1'b0; found <= 1'b0;
      end
      if (cmd.scan_step) begin
        if (!used[ptr]) begin
          found <= 1'b1;
          slot <= ptr;
        end else if (ptr == LAST) begin
          ptr <= AW'(1);
          wrapped <= 1'b1;
        end else ptr <= ptr + AW'(1);
      end
      if (cmd.exec) begin
        status <= 3'(ght_pkg::ST_OK);
        granted_index <= '0; granted_reuse <= '0; found_object <= '0;
        entry_type <= '0; is_valid <= 1'b0;
        if (alloc) begin
          if (!found) status <= 3'(ght_pkg::ST_FULL);
          else begin
            used[slot] <= 1'b1;
            hint <= (slot == LAST) ? AW'(1) : slot + AW'(1);
            live <= live + LW'(1);
            granted_index <= 16'(slot);
            granted_reuse <= new_reuse;
          end
        end else if (op > 3'(ght_pkg::OP_VALID)) status <= 3'(ght_pkg::ST_RANGE);
        else if (stock) begin
          status <= 3'(ght_pkg::ST_STOCK);
          if (op == 3'(ght_pkg::OP_ANY)) entry_type <= typ;
          if (op == 3'(ght_pkg::OP_VALID)) is_valid <= 1'b1;
        end else if (bad) status <= 3'(ght_pkg::ST_RANGE);
        else if (!used[idx[AW-1:0]]) status <= 3'(ght_pkg::ST_UNUSED);
        else begin
          case (op)
            3'(ght_pkg::OP_FREE): begin
              if (r_type != typ) status <= 3'(ght_pkg::ST_TYPE);
              else begin
                used[idx[AW-1:0]] <= 1'b0;
                live <= live - LW'(1);
                if (idx[AW-1:0] < hint) hint <= idx[AW-1:0];
              end
            end
            3'(ght_pkg::OP_TYPED): begin
              if (r_type != typ) status <= 3'(ght_pkg::ST_TYPE);
              else if (r_reuse != tag) status <= 3'(ght_pkg::ST_STALE);
              else found_object <= r_obj;
            end
            3'(ght_pkg::OP_ANY): begin
              found_object <= r_obj;
              entry_type <= r_type;
            end
            default: is_valid <= 1'b1;
          endcase
        end
      end
      if (cmd.done) done <= 1'b0;
      if (cmd.exec) done <= 1'b1;
    end
  end

  assign live_count = 17'(live);
endmodule

@@ test/tb.sv @@
// testbench for the generational handle table: directed table plus random handle traffic
`timescale 1ns / 1ps
module tb;
  localparam int NSLOT = 1024;
  localparam int NRAND = 480;

  typedef struct packed {
    logic [2:0]  opcode;
    logic [15:0] slot_index;
    logic [7:0]  object_type;
    logic [6:0]  reuse_tag;
    logic        is_stock;
    logic [31:0] object_tag;
  } req_t;

  typedef struct packed {
    logic [2:0]  status;
    logic [15:0] granted_index;
    logic [6:0]  granted_reuse;
    logic [31:0] found_object;
    logic [7:0]  entry_type;
    logic        is_valid;
    logic [16:0] live_count;
  } resp_t;

  typedef struct {
    req_t  req;
    logic  fixed;
    resp_t want;
  } row_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        start = 1'b0;
  logic        busy;
  logic [2:0]  opcode = '0;
  logic [15:0] slot_index = '0;
  logic [7:0]  object_type = '0;
  logic [6:0]  reuse_tag = '0;
  logic        is_stock = 1'b0;
  logic [31:0] object_tag = '0;
  logic        done;
  logic [2:0]  status;
  logic [15:0] granted_index;
  logic [6:0]  granted_reuse;
  logic [31:0] found_object;
  logic [7:0]  entry_type;
  logic        is_valid;
  logic [16:0] live_count;

  generational_handle_table_top #(.SLOT_COUNT(NSLOT)) dut (.*);

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // shadow table
  logic        m_used [NSLOT];
  logic [7:0]  m_type [NSLOT];
  logic [6:0]  m_reuse [NSLOT];
  logic [31:0] m_obj [NSLOT];
  int          m_hint;
  int          m_live;

  resp_t pending_resp[$];
  int    errors = 0;
  int    n_items = 0;
  int    n_results = 0;
  int    n_full = 0;
  row_t  rows[$];

  function automatic resp_t table_apply(req_t r);
    resp_t o;
    int s;
    logic bad;
    o = '0;
    bad = (r.slot_index == 0) || (r.slot_index >= NSLOT);
    if (r.opcode == ght_pkg::OP_ALLOC) begin
      s = 0;
      for (int i = m_hint; i < NSLOT; i++)
        if (s == 0 && !m_used[i]) s = i;
      for (int i = 1; i < m_hint; i++)
        if (s == 0 && !m_used[i]) s = i;
      if (s == 0) o.status = ght_pkg::ST_FULL;
      else begin
        m_used[s] = 1'b1;
        m_type[s] = r.object_type;
        m_obj[s] = r.object_tag;
        m_reuse[s] = m_reuse[s] + 7'd1;
        m_hint = (s + 1 >= NSLOT) ? 1 : s + 1;
        m_live++;
        o.granted_index = 16'(s);
        o.granted_reuse = m_reuse[s];
      end
    end else if (r.opcode > ght_pkg::OP_VALID) o.status = ght_pkg::ST_RANGE;
    else if (r.is_stock) begin
      o.status = ght_pkg::ST_STOCK;
      if (r.opcode == ght_pkg::OP_ANY) o.entry_type = r.object_type;
      if (r.opcode == ght_pkg::OP_VALID) o.is_valid = 1'b1;
    end else if (bad) o.status = ght_pkg::ST_RANGE;
    else if (!m_used[r.slot_index]) o.status = ght_pkg::ST_UNUSED;
    else if (r.opcode == ght_pkg::OP_FREE) begin
      if (m_type[r.slot_index] != r.object_type) o.status = ght_pkg::ST_TYPE;
      else begin
        m_used[r.slot_index] = 1'b0;
        m_obj[r.slot_index] = '0;
        m_live--;
        if (r.slot_index < m_hint) m_hint = r.slot_index;
      end
    end else if (r.opcode == ght_pkg::OP_TYPED) begin
      if (m_type[r.slot_index] != r.object_type) o.status = ght_pkg::ST_TYPE;
      else if (m_reuse[r.slot_index] != r.reuse_tag) o.status = ght_pkg::ST_STALE;
      else o.found_object = m_obj[r.slot_index];
    end else if (r.opcode == ght_pkg::OP_ANY) begin
      o.found_object = m_obj[r.slot_index];
      o.entry_type = m_type[r.slot_index];
    end else o.is_valid = 1'b1;
    o.live_count = 17'(m_live);
    if (o.status == ght_pkg::ST_FULL) n_full++;
    return o;
  endfunction

  task automatic send_item(req_t r, logic fixed, resp_t want);
    resp_t p;
    @(posedge clk);
    while ($urandom_range(99) < 35 && (n_items < 150 || n_items >= 300))
      @(posedge clk);
    start <= 1'b1;
    opcode <= r.opcode;
    slot_index <= r.slot_index;
    object_type <= r.object_type;
    reuse_tag <= r.reuse_tag;
    is_stock <= r.is_stock;
    object_tag <= r.object_tag;
    do @(posedge clk); while (busy);
    p = table_apply(r);
    if (fixed && p != want) begin
      $display("%0t directed row %0d: table expects %h, row says %h", $time, n_items, p, want);
      errors++;
    end
    pending_resp.push_back(p);
    n_items++;
    start <= 1'b0;
  endtask

  always @(posedge clk) begin
    resp_t got, exp;
    if (!rst && done) begin
      got = '{status, granted_index, granted_reuse, found_object, entry_type,
              is_valid, live_count};
      n_results++;
      if (pending_resp.size() == 0) begin
        $display("%0t unexpected result %h", $time, got);
        errors++;
      end else begin
        exp = pending_resp.pop_front();
        if (got.status != exp.status) begin
          $display("%0t status exp %0d got %0d", $time, exp.status, got.status); errors++; end
        if (got.granted_index != exp.granted_index) begin
          $display("%0t granted_index exp %0d got %0d", $time, exp.granted_index,
                   got.granted_index); errors++; end
        if (got.granted_reuse != exp.granted_reuse) begin
          $display("%0t granted_reuse exp %0d got %0d", $time, exp.granted_reuse,
                   got.granted_reuse); errors++; end
        if (got.found_object != exp.found_object) begin
          $display("%0t found_object exp %h got %h", $time, exp.found_object,
                   got.found_object); errors++; end
        if (got.entry_type != exp.entry_type) begin
          $display("%0t entry_type exp %0d got %0d", $time, exp.entry_type, got.entry_type);
          errors++; end
        if (got.is_valid != exp.is_valid) begin
          $display("%0t is_valid exp %0d got %0d", $time, exp.is_valid, got.is_valid);
          errors++; end
        if (got.live_count != exp.live_count) begin
          $display("%0t live_count exp %0d got %0d", $time, exp.live_count, got.live_count);
          errors++; end
      end
    end
  end

  function automatic req_t mk(logic [2:0] op, logic [15:0] idx, logic [7:0] ty,
                              logic [6:0] rt, logic st, logic [31:0] ob);
    req_t r;
    r = '{op, idx, ty, rt, st, ob};
    return r;
  endfunction

  function automatic resp_t rs(ght_pkg::status_t st, logic [15:0] gi, logic [6:0] gr,
                               logic [31:0] fo, logic [7:0] et, logic v, logic [16:0] lc);
    resp_t o;
    o = '{st, gi, gr, fo, et, v, lc};
    return o;
  endfunction

  function automatic void add(req_t r, logic f, resp_t w);
    row_t x;
    x.req = r; x.fixed = f; x.want = w;
    rows.push_back(x);
  endfunction

  function automatic req_t rand_item();
    req_t r;
    int k;
    r.opcode = ght_pkg::OP_ALLOC;
    r.object_type = 8'($urandom_range(3));
    r.reuse_tag = 7'($urandom_range(127));
    r.is_stock = ($urandom_range(19) == 0);
    r.object_tag = $urandom;
    k = $urandom_range(99);
    if (k < 40) begin
      r.opcode = ght_pkg::OP_ALLOC;
      if ($urandom_range(9) == 0) r.object_type = 8'($urandom);
      r.slot_index = 16'($urandom);
    end else begin
      r.opcode = 3'($urandom_range(ght_pkg::OP_FREE, ght_pkg::OP_VALID));
      if (k > 96) r.opcode = 3'($urandom_range(5, 7));
      r.slot_index = 16'($urandom_range(1, 12));
      if (k > 90) r.slot_index = 16'($urandom);
      if (k < 80) begin
        for (int t = 0; t < 20; t++)
          if (!m_used[r.slot_index]) r.slot_index = 16'($urandom_range(1, 12));
        if (r.slot_index < NSLOT && $urandom_range(3) != 0) begin
          r.object_type = m_type[r.slot_index];
          r.reuse_tag = m_reuse[r.slot_index];
        end
      end
    end
    return r;
  endfunction

  initial begin
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    for (int i = 0; i < NSLOT; i++) begin
      m_used[i] = (i == 0); m_type[i] = '0; m_reuse[i] = '0; m_obj[i] = '0;
    end
    m_hint = 1; m_live = 1;

    add(mk(ght_pkg::OP_VALID, 16'd0, 8'd0, 7'd0, 1'b0, 32'd0), 1,
        rs(ght_pkg::ST_RANGE, 0, 0, 0, 0, 0, 1));
    add(mk(ght_pkg::OP_VALID, 16'hFFFF, 8'd0, 7'd0, 1'b0, 32'd0), 1,
        rs(ght_pkg::ST_RANGE, 0, 0, 0, 0, 0, 1));
    add(mk(ght_pkg::OP_VALID, 16'd5, 8'd0, 7'd0, 1'b0, 32'd0), 1,
        rs(ght_pkg::ST_UNUSED, 0, 0, 0, 0, 0, 1));
    add(mk(ght_pkg::OP_ALLOC, 16'hFFFF, 8'hFF, 7'h7F, 1'b1, 32'hFFFF_FFFF), 1,
        rs(ght_pkg::ST_OK, 1, 1, 0, 0, 0, 2));
    add(mk(ght_pkg::OP_ALLOC, 16'd0, 8'd0, 7'd0, 1'b0, 32'd0), 1,
        rs(ght_pkg::ST_OK, 2, 1, 0, 0, 0, 3));
    add(mk(ght_pkg::OP_TYPED, 16'd1, 8'hFF, 7'd1, 1'b0, 32'd0), 1,
        rs(ght_pkg::ST_OK, 0, 0, 32'hFFFF_FFFF, 0, 0, 3));
    add(mk(ght_pkg::OP_TYPED, 16'd1, 8'hFF, 7'd2, 1'b0, 32'd0), 1,
        rs(ght_pkg::ST_STALE, 0, 0, 0, 0, 0, 3));
    add(mk(ght_pkg::OP_TYPED, 16'd1, 8'h00, 7'd1, 1'b0, 32'd0), 1,
        rs(ght_pkg::ST_TYPE, 0, 0, 0, 0, 0, 3));
    add(mk(ght_pkg::OP_ANY, 16'd1, 8'd0, 7'd0, 1'b0, 32'd0), 1,
        rs(ght_pkg::ST_OK, 0, 0, 32'hFFFF_FFFF, 8'hFF, 0, 3));
    add(mk(ght_pkg::OP_ANY, 16'd0, 8'hA5, 7'd0, 1'b1, 32'd0), 1,
        rs(ght_pkg::ST_STOCK, 0, 0, 0, 8'hA5, 0, 3));
    add(mk(ght_pkg::OP_VALID, 16'hFFFF, 8'd0, 7'd0, 1'b1, 32'd0), 1,
        rs(ght_pkg::ST_STOCK, 0, 0, 0, 0, 1, 3));
    add(mk(ght_pkg::OP_FREE, 16'd1, 8'd0, 7'd0, 1'b1, 32'd0), 1,
        rs(ght_pkg::ST_STOCK, 0, 0, 0, 0, 0, 3));
    add(mk(ght_pkg::OP_TYPED, 16'd1, 8'hFF, 7'd1, 1'b1, 32'd0), 1,
        rs(ght_pkg::ST_STOCK, 0, 0, 0, 0, 0, 3));
    add(mk(ght_pkg::OP_FREE, 16'd1, 8'h00, 7'd0, 1'b0, 32'd0), 1,
        rs(ght_pkg::ST_TYPE, 0, 0, 0, 0, 0, 3));
    add(mk(ght_pkg::OP_FREE, 16'd1, 8'hFF, 7'd0, 1'b0, 32'd0), 1,
        rs(ght_pkg::ST_OK, 0, 0, 0, 0, 0, 2));
    add(mk(ght_pkg::OP_FREE, 16'd1, 8'hFF, 7'd0, 1'b0, 32'd0), 1,
        rs(ght_pkg::ST_UNUSED, 0, 0, 0, 0, 0, 2));
    add(mk(ght_pkg::OP_VALID, 16'd2, 8'd0, 7'd0, 1'b0, 32'd0), 1,
        rs(ght_pkg::ST_OK, 0, 0, 0, 0, 1, 2));
    add(mk(3'd5, 16'd2, 8'd0, 7'd0, 1'b0, 32'd0), 1,
        rs(ght_pkg::ST_RANGE, 0, 0, 0, 0, 0, 2));
    add(mk(3'd7, 16'd2, 8'd0, 7'd0, 1'b1, 32'd0), 1,
        rs(ght_pkg::ST_RANGE, 0, 0, 0, 0, 0, 2));
    add(mk(ght_pkg::OP_ALLOC, 16'd0, 8'h5A, 7'd0, 1'b0, 32'h1234_5678), 1,
        rs(ght_pkg::ST_OK, 1, 2, 0, 0, 0, 3));
    add(mk(ght_pkg::OP_ANY, 16'd1024, 8'd0, 7'd0, 1'b0, 32'd0), 1,
        rs(ght_pkg::ST_RANGE, 0, 0, 0, 0, 0, 3));
    add(mk(ght_pkg::OP_ANY, 16'd1023, 8'd0, 7'd0, 1'b0, 32'd0), 1,
        rs(ght_pkg::ST_UNUSED, 0, 0, 0, 0, 0, 3));
    foreach (rows[i]) send_item(rows[i].req, rows[i].fixed, rows[i].want);

    for (int i = 0; i < NRAND; i++) begin
      if (i == 200) begin
        while (pending_resp.size() != 0) @(posedge clk);
      end
      send_item(rand_item(), 1'b0, '0);
    end

    while (pending_resp.size() != 0) @(posedge clk);
    repeat (50) @(posedge clk);
    $display("%0d items sent, %0d results checked, %0d table-full answers", n_items,
             n_results, n_full);
    $display("covered all opcodes, stock and range handles, type and stale reuse errors");
    if (errors == 0 && pending_resp.size() == 0)
      $display("Regression PASS");
    else
      $display("Regression FAIL");
    $finish;
  end

  initial begin
    #50ms;
    $display("Regression FAIL");
    $finish;
  end
endmodule
